>>> hw/rtl/ptsd_pkg.sv
// shared types and constants for the point to tapered segment distance block
// no dependencies; imported by ptsd_front, the top level and the testbench
package ptsd_pkg;

    localparam int COORD_W = 16;
    localparam int VS_W    = 16;
    localparam int SD_W    = 25;   // signed scaled difference, Q.8
    localparam int SQ_W    = 50;   // signed product of two scaled values
    localparam int NORM_W  = 50;   // squared norm, Q.16
    localparam int DOT_W   = 51;   // signed dot product, Q.16
    localparam int RAD_W   = 24;   // scaled radius, Q.8
    localparam int HALF_W  = 25;   // half of a norm-wide operand
    localparam int NUM_W   = 100;  // dividend width
    localparam int ROOT_W  = 25;
    localparam int RSUB_W  = 26;   // signed radius subtracted at the end
    localparam int DIST_W  = 32;
    localparam int PART_W  = 2;
    localparam int ITEM_W  = 11 * COORD_W;
    localparam int IDX_W   = 2;

    localparam logic [PART_W-1:0] PART_BOTTOM = 2'd0;
    localparam logic [PART_W-1:0] PART_TOP    = 2'd1;
    localparam logic [PART_W-1:0] PART_SIDE   = 2'd2;
    localparam logic [PART_W-1:0] PART_NONE   = 2'd3;

    localparam logic [IDX_W-1:0] REG_VOXEL_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_VOXEL_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_VOXEL_Z = 2'd2;

    localparam logic [VS_W-1:0] VOXEL_RESET = 16'd4096;

    // input item, first field in the lowest bits
    typedef struct packed {
        logic [COORD_W-1:0] top_radius;
        logic [COORD_W-1:0] top_z;
        logic [COORD_W-1:0] top_y;
        logic [COORD_W-1:0] top_x;
        logic [COORD_W-1:0] bottom_radius;
        logic [COORD_W-1:0] bottom_z;
        logic [COORD_W-1:0] bottom_y;
        logic [COORD_W-1:0] bottom_x;
        logic [COORD_W-1:0] point_z;
        logic [COORD_W-1:0] point_y;
        logic [COORD_W-1:0] point_x;
    } t_item;

    // norms and dot product out of the front end
    typedef struct packed {
        logic [NORM_W-1:0]        normtb;
        logic [NORM_W-1:0]        normbp;
        logic [NORM_W-1:0]        normtp;
        logic signed [DOT_W-1:0]  dot;
        logic [RAD_W-1:0]         rbs;
        logic [RAD_W-1:0]         rts;
    } t_geom;

    // data that rides alongside the divider
    typedef struct packed {
        logic [PART_W-1:0] part;
        logic              neg;
        logic [RAD_W-1:0]  rbs;
        logic [RAD_W-1:0]  rts;
        logic [NORM_W-1:0] normbp;
        logic [NORM_W-1:0] normtp;
    } t_div_side;

    // data that rides alongside the square root
    typedef struct packed {
        logic [PART_W-1:0]        part;
        logic signed [RSUB_W-1:0] rsub;
    } t_sqrt_side;

    localparam int DIV_SIDE_W  = $bits(t_div_side);
    localparam int SQRT_SIDE_W = $bits(t_sqrt_side);

endpackage

>>> hw/rtl/ptsd_front.sv
// front end: axis differences, voxel scaling, squares and dot product
// four register stages; depends on ptsd_pkg
module ptsd_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  ptsd_pkg::t_item        i_item,
    input  logic [ptsd_pkg::VS_W-1:0] i_vs_x,
    input  logic [ptsd_pkg::VS_W-1:0] i_vs_y,
    input  logic [ptsd_pkg::VS_W-1:0] i_vs_z,
    output logic                   o_valid,
    output ptsd_pkg::t_geom        o_geom
);
    import ptsd_pkg::*;

    logic [COORD_W-1:0] w_p [3];
    logic [COORD_W-1:0] w_b [3];
    logic [COORD_W-1:0] w_t [3];
    logic [VS_W-1:0]    w_vs [3];

    assign w_p[0] = i_item.point_x;
    assign w_p[1] = i_item.point_y;
    assign w_p[2] = i_item.point_z;
    assign w_b[0] = i_item.bottom_x;
    assign w_b[1] = i_item.bottom_y;
    assign w_b[2] = i_item.bottom_z;
    assign w_t[0] = i_item.top_x;
    assign w_t[1] = i_item.top_y;
    assign w_t[2] = i_item.top_z;
    assign w_vs[0] = i_vs_x;
    assign w_vs[1] = i_vs_y;
    assign w_vs[2] = i_vs_z;

    // stage 1: magnitudes and signs of the differences
    logic [COORD_W-1:0] r_s1_tb_mag [3], n_s1_tb_mag [3];
    logic [COORD_W-1:0] r_s1_bp_mag [3], n_s1_bp_mag [3];
    logic [COORD_W-1:0] r_s1_tp_mag [3], n_s1_tp_mag [3];
    logic               r_s1_tb_neg [3], n_s1_tb_neg [3];
    logic               r_s1_bp_neg [3], n_s1_bp_neg [3];
    logic               r_s1_tp_neg [3], n_s1_tp_neg [3];
    logic [COORD_W-1:0] r_s1_rb, r_s1_rt;
    logic               r_s1_valid;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_s1_tb_neg[k] = w_t[k] < w_b[k];
            n_s1_tb_mag[k] = n_s1_tb_neg[k] ? w_b[k] - w_t[k] : w_t[k] - w_b[k];
            n_s1_bp_neg[k] = w_b[k] < w_p[k];
            n_s1_bp_mag[k] = n_s1_bp_neg[k] ? w_p[k] - w_b[k] : w_b[k] - w_p[k];
            n_s1_tp_neg[k] = w_t[k] < w_p[k];
            n_s1_tp_mag[k] = n_s1_tp_neg[k] ? w_p[k] - w_t[k] : w_t[k] - w_p[k];
        end
    end

    // stage 2: scaled differences, rounded half up on the magnitude
    logic signed [SD_W-1:0] r_s2_tb [3], n_s2_tb [3];
    logic signed [SD_W-1:0] r_s2_bp [3], n_s2_bp [3];
    logic signed [SD_W-1:0] r_s2_tp [3], n_s2_tp [3];
    logic [RAD_W-1:0]       r_s2_rbs, r_s2_rts, n_s2_rbs, n_s2_rts;
    logic                   r_s2_valid;

    function automatic logic [SD_W-1:0] scale_round(input logic [COORD_W-1:0] m,
                                                    input logic [VS_W-1:0] vs);
        logic [COORD_W+VS_W-1:0] prod;
        logic [COORD_W+VS_W:0]   sum;
        prod = m * vs;
        sum  = {1'b0, prod} + (COORD_W+VS_W+1)'(128);
        return sum[COORD_W+VS_W:8];
    endfunction

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_s2_tb[k] = r_s1_tb_neg[k] ? -$signed(scale_round(r_s1_tb_mag[k], w_vs[k]))
                                        :  $signed(scale_round(r_s1_tb_mag[k], w_vs[k]));
            n_s2_bp[k] = r_s1_bp_neg[k] ? -$signed(scale_round(r_s1_bp_mag[k], w_vs[k]))
                                        :  $signed(scale_round(r_s1_bp_mag[k], w_vs[k]));
            n_s2_tp[k] = r_s1_tp_neg[k] ? -$signed(scale_round(r_s1_tp_mag[k], w_vs[k]))
                                        :  $signed(scale_round(r_s1_tp_mag[k], w_vs[k]));
        end
        n_s2_rbs = RAD_W'(scale_round(r_s1_rb, i_vs_x));
        n_s2_rts = RAD_W'(scale_round(r_s1_rt, i_vs_x));
    end

    // stage 3: products
    logic signed [SQ_W-1:0] r_s3_tb2 [3], r_s3_bp2 [3], r_s3_tp2 [3], r_s3_dot [3];
    logic [RAD_W-1:0]       r_s3_rbs, r_s3_rts;
    logic                   r_s3_valid;

    // stage 4: sums
    logic [NORM_W-1:0] n_s4_normtb, n_s4_normbp, n_s4_normtp;
    logic signed [DOT_W-1:0] n_s4_dot;
    logic signed [SQ_W+1:0]  w_sum_tb, w_sum_bp, w_sum_tp, w_sum_dot;
    t_geom             r_s4_geom;
    logic              r_s4_valid;

    always_comb begin
        w_sum_tb  = (SQ_W+2)'(r_s3_tb2[0]) + (SQ_W+2)'(r_s3_tb2[1]) + (SQ_W+2)'(r_s3_tb2[2]);
        w_sum_bp  = (SQ_W+2)'(r_s3_bp2[0]) + (SQ_W+2)'(r_s3_bp2[1]) + (SQ_W+2)'(r_s3_bp2[2]);
        w_sum_tp  = (SQ_W+2)'(r_s3_tp2[0]) + (SQ_W+2)'(r_s3_tp2[1]) + (SQ_W+2)'(r_s3_tp2[2]);
        w_sum_dot = (SQ_W+2)'(r_s3_dot[0]) + (SQ_W+2)'(r_s3_dot[1]) + (SQ_W+2)'(r_s3_dot[2]);
        n_s4_normtb = w_sum_tb[NORM_W-1:0];
        n_s4_normbp = w_sum_bp[NORM_W-1:0];
        n_s4_normtp = w_sum_tp[NORM_W-1:0];
        n_s4_dot    = w_sum_dot[DOT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_tb_mag <= n_s1_tb_mag;
            r_s1_bp_mag <= n_s1_bp_mag;
            r_s1_tp_mag <= n_s1_tp_mag;
            r_s1_tb_neg <= n_s1_tb_neg;
            r_s1_bp_neg <= n_s1_bp_neg;
            r_s1_tp_neg <= n_s1_tp_neg;
            r_s1_rb     <= i_item.bottom_radius;
            r_s1_rt     <= i_item.top_radius;
            r_s2_tb     <= n_s2_tb;
            r_s2_bp     <= n_s2_bp;
            r_s2_tp     <= n_s2_tp;
            r_s2_rbs    <= n_s2_rbs;
            r_s2_rts    <= n_s2_rts;
            for (int k = 0; k < 3; k++) begin
                r_s3_tb2[k] <= SQ_W'(r_s2_tb[k] * r_s2_tb[k]);
                r_s3_bp2[k] <= SQ_W'(r_s2_bp[k] * r_s2_bp[k]);
                r_s3_tp2[k] <= SQ_W'(r_s2_tp[k] * r_s2_tp[k]);
                r_s3_dot[k] <= SQ_W'(r_s2_bp[k] * r_s2_tb[k]);
            end
            r_s3_rbs <= r_s2_rbs;
            r_s3_rts <= r_s2_rts;
            r_s4_geom.normtb <= n_s4_normtb;
            r_s4_geom.normbp <= n_s4_normbp;
            r_s4_geom.normtp <= n_s4_normtp;
            r_s4_geom.dot    <= n_s4_dot;
            r_s4_geom.rbs    <= r_s3_rbs;
            r_s4_geom.rts    <= r_s3_rts;
        end
    end

    assign o_valid = r_s4_valid;
    assign o_geom  = r_s4_geom;

endmodule

>>> hw/rtl/ptsd_div2.sv
// two-lane pipelined restoring divider sharing one divisor, one quotient bit
// per stage per lane; standalone, no package needed
module ptsd_div2 #(
    parameter int DEN_W  = 50,
    parameter int Q_W    = 50,
    parameter int SIDE_W = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [DEN_W+Q_W-1:0]   i_num_a,
    input  logic [DEN_W+Q_W-1:0]   i_num_b,
    input  logic [DEN_W-1:0]       i_den,
    input  logic [SIDE_W-1:0]      i_side,
    output logic                   o_valid,
    output logic [Q_W-1:0]         o_quo_a,
    output logic [Q_W-1:0]         o_quo_b,
    output logic [SIDE_W-1:0]      o_side
);
    logic [DEN_W-1:0]  r_rem_a [Q_W];
    logic [DEN_W-1:0]  r_rem_b [Q_W];
    logic [Q_W-1:0]    r_lo_a  [Q_W];
    logic [Q_W-1:0]    r_lo_b  [Q_W];
    logic [Q_W-1:0]    r_q_a   [Q_W];
    logic [Q_W-1:0]    r_q_b   [Q_W];
    logic [DEN_W-1:0]  r_den   [Q_W];
    logic [SIDE_W-1:0] r_side  [Q_W];
    logic              r_valid [Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_stage
        logic [DEN_W-1:0]  rem_a, rem_b, den;
        logic [Q_W-1:0]    lo_a, lo_b, q_a, q_b;
        logic [SIDE_W-1:0] side;
        logic              valid;
        logic [DEN_W:0]    sh_a, sh_b;
        logic              ge_a, ge_b;
        logic [DEN_W:0]    n_rem_a, n_rem_b;

        if (j == 0) begin : g_first
            assign rem_a = i_num_a[DEN_W+Q_W-1:Q_W];
            assign rem_b = i_num_b[DEN_W+Q_W-1:Q_W];
            assign lo_a  = i_num_a[Q_W-1:0];
            assign lo_b  = i_num_b[Q_W-1:0];
            assign q_a   = '0;
            assign q_b   = '0;
            assign den   = i_den;
            assign side  = i_side;
            assign valid = i_valid;
        end else begin : g_next
            assign rem_a = r_rem_a[j-1];
            assign rem_b = r_rem_b[j-1];
            assign lo_a  = r_lo_a[j-1];
            assign lo_b  = r_lo_b[j-1];
            assign q_a   = r_q_a[j-1];
            assign q_b   = r_q_b[j-1];
            assign den   = r_den[j-1];
            assign side  = r_side[j-1];
            assign valid = r_valid[j-1];
        end

        always_comb begin
            sh_a    = {rem_a, lo_a[Q_W-1]};
            sh_b    = {rem_b, lo_b[Q_W-1]};
            ge_a    = sh_a >= {1'b0, den};
            ge_b    = sh_b >= {1'b0, den};
            n_rem_a = ge_a ? sh_a - {1'b0, den} : sh_a;
            n_rem_b = ge_b ? sh_b - {1'b0, den} : sh_b;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else if (i_en) begin
                r_valid[j] <= valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_a[j] <= n_rem_a[DEN_W-1:0];
                r_rem_b[j] <= n_rem_b[DEN_W-1:0];
                r_lo_a[j]  <= lo_a << 1;
                r_lo_b[j]  <= lo_b << 1;
                r_q_a[j]   <= {q_a[Q_W-2:0], ge_a};
                r_q_b[j]   <= {q_b[Q_W-2:0], ge_b};
                r_den[j]   <= den;
                r_side[j]  <= side;
            end
        end
    end

    assign o_valid = r_valid[Q_W-1];
    assign o_quo_a = r_q_a[Q_W-1];
    assign o_quo_b = r_q_b[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule

>>> hw/rtl/ptsd_sqrt.sv
// pipelined digit-by-digit floor square root, one result bit per stage
// standalone, no package needed
module ptsd_sqrt #(
    parameter int ARG_W  = 50,
    parameter int SIDE_W = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [ARG_W-1:0]      i_arg,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic [ARG_W/2-1:0]    o_root,
    output logic [SIDE_W-1:0]     o_side
);
    localparam int RT_W  = ARG_W / 2;
    localparam int REM_W = RT_W + 2;

    logic [REM_W-1:0]  r_rem   [RT_W];
    logic [RT_W-1:0]   r_root  [RT_W];
    logic [ARG_W-1:0]  r_arg   [RT_W];
    logic [SIDE_W-1:0] r_side  [RT_W];
    logic              r_valid [RT_W];

    for (genvar j = 0; j < RT_W; j++) begin : g_stage
        logic [REM_W-1:0]  rem;
        logic [RT_W-1:0]   root;
        logic [ARG_W-1:0]  arg;
        logic [SIDE_W-1:0] side;
        logic              valid;
        logic [REM_W+1:0]  sh, trial, n_rem;
        logic              ge;

        if (j == 0) begin : g_first
            assign rem   = '0;
            assign root  = '0;
            assign arg   = i_arg;
            assign side  = i_side;
            assign valid = i_valid;
        end else begin : g_next
            assign rem   = r_rem[j-1];
            assign root  = r_root[j-1];
            assign arg   = r_arg[j-1];
            assign side  = r_side[j-1];
            assign valid = r_valid[j-1];
        end

        always_comb begin
            sh    = {rem, arg[ARG_W-1:ARG_W-2]};
            trial = {2'b00, root, 2'b01};
            ge    = sh >= trial;
            n_rem = ge ? sh - trial : sh;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else if (i_en) begin
                r_valid[j] <= valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= n_rem[REM_W-1:0];
                r_root[j] <= {root[RT_W-2:0], ge};
                r_arg[j]  <= arg << 2;
                r_side[j] <= side;
            end
        end
    end

    assign o_valid = r_valid[RT_W-1];
    assign o_root  = r_root[RT_W-1];
    assign o_side  = r_side[RT_W-1];

endmodule

>>> hw/rtl/point_to_tapered_segment_distance_top.sv
// top level of the point to tapered segment distance block
// uses ptsd_pkg, ptsd_front, ptsd_div2 and ptsd_sqrt
//
// one point/segment pair enters per clock and one result leaves per clock,
// while the pipeline advances. the path runs through two long
// pipelines: a 50-stage divider that forms the projection terms (one
// quotient bit per stage) and a 25-stage square root (one root bit per
// stage), plus four front-end stages for scaling, squares and sums, four
// stages for classification, partial products and radius selection, and
// the output register. the whole pipeline advances together; it holds only
// while a result sits in the output register and the sink is not ready, so
// a new pair is taken in the same cycle a waiting result is taken.
// voxel size registers are written through the config channel, which is
// always ready; write them only while no pair is in flight.
module point_to_tapered_segment_distance_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ptsd_pkg::IDX_W-1:0]      i_cfg_index,
    input  logic [ptsd_pkg::VS_W-1:0]       i_cfg_data,
    // input stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // point_x, point_y, point_z, bottom_x, bottom_y, bottom_z, bottom_radius,
    // top_x, top_y, top_z, top_radius (16 bits each, lowest first)
    input  logic [ptsd_pkg::ITEM_W-1:0]     i_s_axis_tdata,
    // output stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // surface_distance, signed q24.8
    output logic [ptsd_pkg::DIST_W-1:0]     o_m_axis_tdata,
    // nearest_part: 0 bottom end, 1 top end, 2 side
    output logic [ptsd_pkg::PART_W-1:0]     o_m_axis_tuser
);
    import ptsd_pkg::*;

    // global pipeline advance
    logic w_en;
    logic r_out_valid;
    assign w_en = !r_out_valid || i_m_axis_tready;

    // voxel size registers
    logic [VS_W-1:0] r_vs_x, r_vs_y, r_vs_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs_x <= VOXEL_RESET;
            r_vs_y <= VOXEL_RESET;
            r_vs_z <= VOXEL_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_VOXEL_X: r_vs_x <= i_cfg_data;
                REG_VOXEL_Y: r_vs_y <= i_cfg_data;
                REG_VOXEL_Z: r_vs_z <= i_cfg_data;
                default: ;  // index beyond the register list is dropped
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // front end: scaled vectors, norms, dot product
    logic  w_geom_valid;
    t_geom w_geom;

    ptsd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_item  (t_item'(i_s_axis_tdata)),
        .i_vs_x  (r_vs_x),
        .i_vs_y  (r_vs_y),
        .i_vs_z  (r_vs_z),
        .o_valid (w_geom_valid),
        .o_geom  (w_geom)
    );

    // stage 5: pick the nearest part, negate the dot product, radius delta
    logic                    w_s5_bottom, w_s5_top;
    logic [DOT_W-1:0]        w_s5_nd;
    logic signed [RAD_W:0]   w_s5_dr;
    t_div_side               n_s5_side, r_s5_side;
    logic [NORM_W-1:0]       r_s5_nd, r_s5_normtb;
    logic [RAD_W-1:0]        r_s5_mag;
    logic                    r_s5_valid;

    always_comb begin
        w_s5_nd     = DOT_W'(-w_geom.dot);
        // zero-length axis or projection before the bottom end
        w_s5_bottom = (w_geom.normtb == '0) || (!w_geom.dot[DOT_W-1] && w_geom.dot != '0);
        w_s5_top    = !w_s5_bottom && (w_s5_nd > {1'b0, w_geom.normtb});
        w_s5_dr     = $signed({1'b0, w_geom.rts}) - $signed({1'b0, w_geom.rbs});
        n_s5_side.part   = w_s5_bottom ? PART_BOTTOM : (w_s5_top ? PART_TOP : PART_SIDE);
        n_s5_side.neg    = w_s5_dr[RAD_W];
        n_s5_side.rbs    = w_geom.rbs;
        n_s5_side.rts    = w_geom.rts;
        n_s5_side.normbp = w_geom.normbp;
        n_s5_side.normtp = w_geom.normtp;
    end

    // stage 6: partial products of nd*nd and |dr|*nd
    logic [2*HALF_W-1:0]       r_s6_hh, r_s6_hl, r_s6_ll;
    logic [RAD_W+HALF_W-1:0]   r_s6_mh, r_s6_ml;
    logic [NORM_W-1:0]         r_s6_normtb;
    t_div_side                 r_s6_side;
    logic                      r_s6_valid;

    // stage 7: dividends, the second one carries the rounding half
    logic [NUM_W-1:0] r_s7_num_q, r_s7_num_a;
    logic [NORM_W-1:0] r_s7_den;
    t_div_side        r_s7_side;
    logic             r_s7_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
            r_s7_valid <= 1'b0;
        end else if (w_en) begin
            r_s5_valid <= w_geom_valid;
            r_s6_valid <= r_s5_valid;
            r_s7_valid <= r_s6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_side   <= n_s5_side;
            r_s5_nd     <= w_s5_nd[NORM_W-1:0];
            r_s5_normtb <= w_geom.normtb;
            r_s5_mag    <= w_s5_dr[RAD_W] ? RAD_W'(-w_s5_dr) : w_s5_dr[RAD_W-1:0];

            r_s6_hh     <= r_s5_nd[NORM_W-1:HALF_W] * r_s5_nd[NORM_W-1:HALF_W];
            r_s6_hl     <= r_s5_nd[NORM_W-1:HALF_W] * r_s5_nd[HALF_W-1:0];
            r_s6_ll     <= r_s5_nd[HALF_W-1:0] * r_s5_nd[HALF_W-1:0];
            r_s6_mh     <= r_s5_mag * r_s5_nd[NORM_W-1:HALF_W];
            r_s6_ml     <= r_s5_mag * r_s5_nd[HALF_W-1:0];
            r_s6_normtb <= r_s5_normtb;
            r_s6_side   <= r_s5_side;

            r_s7_num_q  <= {r_s6_hh, {(2*HALF_W){1'b0}}}
                         + {{(NUM_W-2*HALF_W-HALF_W-1){1'b0}}, r_s6_hl, {(HALF_W+1){1'b0}}}
                         + {{(NUM_W-2*HALF_W){1'b0}}, r_s6_ll};
            r_s7_num_a  <= {{(NUM_W-RAD_W-2*HALF_W){1'b0}}, r_s6_mh, {HALF_W{1'b0}}}
                         + {{(NUM_W-RAD_W-HALF_W){1'b0}}, r_s6_ml}
                         + {{(NUM_W-NORM_W+1){1'b0}}, r_s6_normtb[NORM_W-1:1]};
            r_s7_den    <= r_s6_normtb;
            r_s7_side   <= r_s6_side;
        end
    end

    // divider: q = nd*nd / normtb and adj = round(|dr|*nd / normtb)
    logic                      w_div_valid;
    logic [NUM_W-NORM_W-1:0]   w_quo_q, w_quo_a;
    logic [DIV_SIDE_W-1:0]     w_div_side_bits;
    t_div_side                 w_div_side;

    ptsd_div2 #(
        .DEN_W  (NORM_W),
        .Q_W    (NUM_W - NORM_W),
        .SIDE_W (DIV_SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s7_valid),
        .i_num_a (r_s7_num_q),
        .i_num_b (r_s7_num_a),
        .i_den   (r_s7_den),
        .i_side  (r_s7_side),
        .o_valid (w_div_valid),
        .o_quo_a (w_quo_q),
        .o_quo_b (w_quo_a),
        .o_side  (w_div_side_bits)
    );

    assign w_div_side = t_div_side'(w_div_side_bits);

    // stage 8: perpendicular distance squared, interpolated radius, root argument
    logic [NORM_W-1:0]        w_perp2, w_q, n_s8_arg, r_s8_arg;
    logic [RAD_W:0]           w_adj;
    logic signed [RSUB_W-1:0] w_r;
    t_sqrt_side               n_s8_side, r_s8_side;
    logic                     r_s8_valid;

    always_comb begin
        w_q     = w_quo_q[NORM_W-1:0];
        w_adj   = w_quo_a[RAD_W:0];
        w_perp2 = (w_div_side.normbp > w_q) ? w_div_side.normbp - w_q : '0;
        w_r     = w_div_side.neg
                ? $signed({2'b00, w_div_side.rbs}) - $signed({1'b0, w_adj})
                : $signed({2'b00, w_div_side.rbs}) + $signed({1'b0, w_adj});
        n_s8_side.part = w_div_side.part;
        case (w_div_side.part)
            PART_BOTTOM: begin
                n_s8_arg       = w_div_side.normbp;
                n_s8_side.rsub = $signed({2'b00, w_div_side.rbs});
            end
            PART_TOP: begin
                n_s8_arg       = w_div_side.normtp;
                n_s8_side.rsub = $signed({2'b00, w_div_side.rts});
            end
            default: begin
                n_s8_arg       = w_perp2;
                n_s8_side.rsub = w_r;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_valid <= 1'b0;
        end else if (w_en) begin
            r_s8_valid <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s8_arg  <= n_s8_arg;
            r_s8_side <= n_s8_side;
        end
    end

    // square root of the selected squared distance
    logic                   w_sqrt_valid;
    logic [ROOT_W-1:0]      w_root;
    logic [SQRT_SIDE_W-1:0] w_sqrt_side_bits;
    t_sqrt_side             w_sqrt_side;

    ptsd_sqrt #(
        .ARG_W  (NORM_W),
        .SIDE_W (SQRT_SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s8_valid),
        .i_arg   (r_s8_arg),
        .i_side  (r_s8_side),
        .o_valid (w_sqrt_valid),
        .o_root  (w_root),
        .o_side  (w_sqrt_side_bits)
    );

    assign w_sqrt_side = t_sqrt_side'(w_sqrt_side_bits);

    // output register: root minus radius; the difference stays within
    // 27 signed bits, so the 32-bit result never reaches the clamp limits
    logic signed [RSUB_W:0]  w_dist;
    logic [DIST_W-1:0]       r_out_dist;
    logic [PART_W-1:0]       r_out_part;

    assign w_dist = $signed({2'b00, w_root}) - $signed({w_sqrt_side.rsub[RSUB_W-1],
                                                       w_sqrt_side.rsub});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_sqrt_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_dist <= DIST_W'(w_dist);
            r_out_part <= w_sqrt_side.part;
        end
    end

    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_dist;
    assign o_m_axis_tuser  = r_out_part;

    // the unused part code never reaches the output
    a_part_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser != PART_NONE)
        else $error("unused nearest part code at output");

    // projection term never exceeds the squared bottom distance on the side
    a_proj_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_valid && w_div_side.part == PART_SIDE) |-> w_q <= w_div_side.normbp)
        else $error("projection term larger than squared bottom distance");

    // interpolated radius stays between the two end radii, so never negative
    a_radius_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s8_valid |-> !r_s8_side.rsub[RSUB_W-1])
        else $error("negative radius entering square root stage");

    // a stall freezes the middle of the pipeline
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_s8_valid) && $stable(r_s7_valid)))
        else $error("pipeline moved during a stall");

endmodule

>>> dv/point_to_tapered_segment_distance_top_tb.sv
// testbench for point_to_tapered_segment_distance_top: directed and random pairs
// under several voxel size settings, each result checked against a local predictor
// depends on ptsd_pkg and the block's rtl only
module point_to_tapered_segment_distance_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptsd_pkg::*;

    // index past the register list, writes to it must be dropped
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PIPE_LAT    = 84;

    typedef struct {
        logic signed [DIST_W-1:0] distance;
        logic [PART_W-1:0]        part;
    } t_dist_result;

    // distance predictor and store of expected distances
    class distance_scoreboard;
        logic [VS_W-1:0] voxel_x, voxel_y, voxel_z;
        t_dist_result    pending_q[$];
        int              errors;

        function new();
            voxel_x = VOXEL_RESET;
            voxel_y = VOXEL_RESET;
            voxel_z = VOXEL_RESET;
            errors  = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [VS_W-1:0] value);
            case (idx)
                REG_VOXEL_X: voxel_x = value;
                REG_VOXEL_Y: voxel_y = value;
                REG_VOXEL_Z: voxel_z = value;
                default: ;
            endcase
        endfunction

        // signed (a - b) * vs, magnitude rounded half up to q.8
        static function longint scale_diff(longint a, longint b, longint vs);
            longint m;
            longint s;
            m = (a < b) ? b - a : a - b;
            s = (m * vs + 128) >>> 8;
            return (a < b) ? -s : s;
        endfunction

        static function longint floor_sqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return longint'(res);
        endfunction

        // floor((a*b + add) / c) in 128-bit arithmetic
        static function longint unsigned mul_div(longint unsigned a, longint unsigned b,
                                                 longint unsigned add, longint unsigned c);
            logic [127:0] num;
            logic [127:0] quo;
            num = 128'(a) * 128'(b) + 128'(add);
            quo = num / 128'(c);
            return quo[63:0];
        endfunction

        function void note_pair(t_item item);
            longint vs[3], pt[3], bt[3], tt[3];
            longint tb[3], bp[3], tp[3];
            longint norm_tb, norm_bp, norm_tp, dotp, surf_dist, rbs, rts, dr, r;
            longint unsigned nd, q, perp2, adj;
            t_dist_result res;
            vs = '{longint'(voxel_x), longint'(voxel_y), longint'(voxel_z)};
            pt = '{longint'(item.point_x), longint'(item.point_y), longint'(item.point_z)};
            bt = '{longint'(item.bottom_x), longint'(item.bottom_y), longint'(item.bottom_z)};
            tt = '{longint'(item.top_x), longint'(item.top_y), longint'(item.top_z)};
            for (int k = 0; k < 3; k++) begin
                tb[k] = scale_diff(tt[k], bt[k], vs[k]);
                bp[k] = scale_diff(bt[k], pt[k], vs[k]);
                tp[k] = scale_diff(tt[k], pt[k], vs[k]);
            end
            // radii use the x voxel size only
            rbs = (longint'(item.bottom_radius) * vs[0] + 128) >>> 8;
            rts = (longint'(item.top_radius) * vs[0] + 128) >>> 8;
            norm_tb = tb[0]*tb[0] + tb[1]*tb[1] + tb[2]*tb[2];
            norm_bp = bp[0]*bp[0] + bp[1]*bp[1] + bp[2]*bp[2];
            norm_tp = tp[0]*tp[0] + tp[1]*tp[1] + tp[2]*tp[2];
            dotp    = bp[0]*tb[0] + bp[1]*tb[1] + bp[2]*tb[2];
            if (norm_tb == 0 || dotp > 0) begin
                // zero-length axis falls here too
                res.part = PART_BOTTOM;
                surf_dist = floor_sqrt(norm_bp) - rbs;
            end else if (-dotp > norm_tb) begin
                res.part = PART_TOP;
                surf_dist = floor_sqrt(norm_tp) - rts;
            end else begin
                nd    = -dotp;
                q     = mul_div(nd, nd, 0, norm_tb);
                perp2 = (norm_bp > q) ? norm_bp - q : 0;
                dr    = rts - rbs;
                adj   = mul_div((dr < 0) ? -dr : dr, nd, norm_tb >> 1, norm_tb);
                r     = (dr < 0) ? rbs - longint'(adj) : rbs + longint'(adj);
                res.part = PART_SIDE;
                surf_dist = floor_sqrt(perp2) - r;
            end
            if (surf_dist > 64'sd2147483647) surf_dist = 64'sd2147483647;
            if (surf_dist < -64'sd2147483648) surf_dist = -64'sd2147483648;
            res.distance = surf_dist[31:0];
            pending_q = {pending_q, res};
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch on %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(logic [DIST_W-1:0] data, logic [PART_W-1:0] user);
            t_dist_result want;
            if (pending_q.size() == 0) begin
                report("unexpected result", signed'(data), 0);
            end else begin
                want = pending_q.pop_front();
                if (data !== want.distance)
                    report("surface_distance", signed'(data), want.distance);
                if (user !== want.part)
                    report("nearest_part", user, want.part);
            end
        endtask

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [IDX_W-1:0]      i_cfg_index;
    logic [VS_W-1:0]       i_cfg_data;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [ITEM_W-1:0]     i_s_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [DIST_W-1:0]     o_m_axis_tdata;
    logic [PART_W-1:0]     o_m_axis_tuser;

    distance_scoreboard sb = new();

    // receiver idling controls
    bit sink_hold;      // long hold-off, set by the pressure process
    bit no_idle;        // stretches with no idling on either side
    int stall_left;
    int cycle_count;

    point_to_tapered_segment_distance_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: check every accepted result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
    end

    // sink readiness, mostly short stalls and a few long ones
    always @(negedge i_clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (sink_hold) begin
            i_m_axis_tready = 1'b0;
        end else if (no_idle) begin
            i_m_axis_tready = 1'b1;
        end else if (stall_left > 0) begin
            i_m_axis_tready = 1'b0;
            stall_left--;
        end else if (r < 70) begin
            i_m_axis_tready = 1'b1;
        end else if (r < 97) begin
            i_m_axis_tready = 1'b0;
            stall_left = $urandom_range(0, 3);
        end else begin
            i_m_axis_tready = 1'b0;
            stall_left = $urandom_range(10, 40);
        end
    end

    // one config write transaction; valid is left high for the caller to drop
    task cfg_write(logic [IDX_W-1:0] idx, logic [VS_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, value);
    endtask

    // stop offering pairs and wait until every expected result has come
    task source_pause();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // let the pipeline drain before touching the registers
    task drain();
        source_pause();
        repeat (PIPE_LAT + 10) @(posedge i_clk);
    endtask

    task set_voxels(logic [VS_W-1:0] vx, logic [VS_W-1:0] vy, logic [VS_W-1:0] vz);
        drain();
        cfg_write(REG_VOXEL_X, vx);
        cfg_write(REG_VOXEL_Y, vy);
        cfg_write(REG_VOXEL_Z, vz);
        // ignored write to the unused index
        cfg_write(REG_UNUSED, 16'($urandom));
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // one input transaction followed by an optional gap
    task send_pair(t_item item);
        int r;
        int gap;
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = item;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_pair(item);
        r   = $urandom_range(0, 99);
        gap = 0;
        if (!no_idle) begin
            if (r >= 97)      gap = $urandom_range(10, 40);
            else if (r >= 65) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    function automatic t_item make_pair(logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                                        logic [15:0] bx, logic [15:0] by, logic [15:0] bz,
                                        logic [15:0] br, logic [15:0] tx, logic [15:0] ty,
                                        logic [15:0] tz, logic [15:0] tr);
        t_item it;
        it.point_x = px; it.point_y = py; it.point_z = pz;
        it.bottom_x = bx; it.bottom_y = by; it.bottom_z = bz; it.bottom_radius = br;
        it.top_x = tx; it.top_y = ty; it.top_z = tz; it.top_radius = tr;
        return it;
    endfunction

    // random pair: full range, or clustered so all three cases come up often
    function automatic t_item random_pair();
        t_item it;
        int mode;
        logic [15:0] base;
        mode = $urandom_range(0, 3);
        if (mode == 0) begin
            it = ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        end else begin
            base = 16'($urandom_range(0, 60000));
            it.point_x  = base + 16'($urandom_range(0, 4000));
            it.point_y  = base + 16'($urandom_range(0, 4000));
            it.point_z  = base + 16'($urandom_range(0, 4000));
            it.bottom_x = base + 16'($urandom_range(0, 4000));
            it.bottom_y = base + 16'($urandom_range(0, 4000));
            it.bottom_z = base + 16'($urandom_range(0, 4000));
            it.top_x    = base + 16'($urandom_range(0, 4000));
            it.top_y    = base + 16'($urandom_range(0, 4000));
            it.top_z    = base + 16'($urandom_range(0, 4000));
            it.bottom_radius = (mode == 1) ? 16'($urandom) : 16'($urandom_range(0, 800));
            it.top_radius    = (mode == 1) ? 16'($urandom) : 16'($urandom_range(0, 800));
        end
        return it;
    endfunction

    task directed_pairs();
        // zero-length segment, all zero and all ones
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
        send_pair(make_pair(0, 0, 0, '1, '1, '1, 0, '1, '1, '1, '1));
        // point before the bottom end, past the top end, beside the axis
        send_pair(make_pair(0, 0, 0, 1600, 1600, 1600, 32, 3200, 3200, 3200, 16));
        send_pair(make_pair('1, '1, '1, 1600, 1600, 1600, 32, 3200, 3200, 3200, 16));
        send_pair(make_pair(0, 3200, 1600, 0, 0, 0, 160, 3200, 0, 0, 48));
        // projection exactly on the bottom end and on the top end
        send_pair(make_pair(100, 100, 100, 100, 100, 100, 80, 900, 100, 100, 40));
        send_pair(make_pair(900, 100, 100, 100, 100, 100, 80, 900, 100, 100, 40));
        // point on the axis inside a fat cone, negative distance
        send_pair(make_pair(500, 0, 0, 0, 0, 0, '1, 1000, 0, 0, '1));
        // longest axis and far points
        send_pair(make_pair('1, 0, '1, 0, '1, 0, '1, '1, 0, '1, 0));
        send_pair(make_pair(0, '1, 0, 0, 0, 0, 0, '1, '1, '1, '1));
        send_pair(make_pair(16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0, '1, '1, '1, 0));
        // radius taper both ways
        send_pair(make_pair(400, 300, 0, 0, 0, 0, 0, 800, 0, 0, '1));
        send_pair(make_pair(400, 300, 0, 0, 0, 0, '1, 800, 0, 0, 0));
        send_pair(make_pair(400, 0, 0, 0, 0, 0, 16'h5555, 800, 0, 0, 16'haaaa));
    endtask

    task random_pairs(int count);
        for (int n = 0; n < count; n++) send_pair(random_pair());
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = REG_VOXEL_X;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        sink_hold       = 1'b0;
        no_idle         = 1'b0;
        stall_left      = 0;
        cycle_count     = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset voxel sizes
        directed_pairs();
        random_pairs(150);

        // unit sizes written explicitly, with a long sink hold-off while
        // the source keeps offering so the pipeline backs up
        set_voxels(VOXEL_RESET, VOXEL_RESET, VOXEL_RESET);
        fork
            begin
                sink_hold = 1'b1;
                repeat (400) @(posedge i_clk);
                sink_hold = 1'b0;
            end
            random_pairs(200);
        join

        // zero voxel sizes collapse every axis
        set_voxels(16'd0, 16'd0, 16'd0);
        directed_pairs();
        random_pairs(60);

        // largest voxel sizes, no idling on either side
        set_voxels('1, '1, '1);
        no_idle = 1'b1;
        directed_pairs();
        random_pairs(200);
        no_idle = 1'b0;

        // mixed sizes, source pauses mid-phase until the pipeline is empty
        set_voxels(16'd0, VOXEL_RESET, '1);
        random_pairs(120);
        source_pause();
        random_pairs(120);

        // random sizes
        for (int s = 0; s < 3; s++) begin
            set_voxels(16'($urandom), 16'($urandom), 16'($urandom));
            random_pairs(170);
        end

        source_pause();
        repeat (PIPE_LAT + 20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/ptsd_pkg.sv
hw/rtl/ptsd_front.sv
hw/rtl/ptsd_div2.sv
hw/rtl/ptsd_sqrt.sv
hw/rtl/point_to_tapered_segment_distance_top.sv
dv/point_to_tapered_segment_distance_top_tb.sv
